// File: hw/rtl/fut_pkg.sv
package fut_pkg;

    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CASE_MASK = 8'hDF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_NAME     = 2'd0,
        KIND_VALUE    = 2'd1,
        KIND_NAME_END = 2'd2,
        KIND_PAIR_END = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ESC_NONE   = 2'd0,
        ESC_FIRST  = 2'd1,
        ESC_SECOND = 2'd2
    } esc_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
    } token_t;

    // Tokens produced by one input byte; count is 1 or 2 for queued entries.
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } push_t;

    typedef struct packed {
        logic   valid;
        logic   full;
        entry_t entry;
    } qstat_t;

    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] r;
        if (c >= 8'h41 && c <= 8'h7F)
        begin
            r = (c & CASE_MASK) - 8'h41 + 8'd10;
        end
        else
        begin
            r = c - 8'h30;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/fut_front.sv
module fut_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             last_byte,
    output fut_pkg::push_t   push
);

    logic             value_reg, value_next;
    fut_pkg::esc_t    esc_reg, esc_next;
    logic [7:0]       hns_reg, hns_next;
    logic             muted_reg, muted_next;

    logic [7:0]       c;
    logic [7:0]       hex;
    logic [7:0]       dec_ch;
    logic             dec_en;
    logic             has_char;
    fut_pkg::token_t  char_tok;
    fut_pkg::token_t  end_tok;
    fut_pkg::entry_t  entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= 1'b0;
            esc_reg   <= fut_pkg::ESC_NONE;
            hns_reg   <= 8'd0;
            muted_reg <= 1'b0;
        end
        else if (accept)
        begin
            value_reg <= value_next;
            esc_reg   <= esc_next;
            hns_reg   <= hns_next;
            muted_reg <= muted_next;
        end
    end

    always_comb
    begin
        c          = (in_byte == fut_pkg::CH_PLUS) ? fut_pkg::CH_SPACE : in_byte;
        hex        = fut_pkg::hex_value(c);
        value_next = value_reg;
        esc_next   = esc_reg;
        hns_next   = hns_reg;
        muted_next = muted_reg;
        dec_ch     = c;
        dec_en     = 1'b0;
        has_char   = 1'b0;
        char_tok   = '{data: 8'd0, kind: fut_pkg::KIND_NAME};
        end_tok    = '{data: 8'd0, kind: fut_pkg::KIND_PAIR_END};

        if (!muted_reg)
        begin
            unique case (esc_reg)
                fut_pkg::ESC_NONE:
                begin
                    if (c == fut_pkg::CH_PCT)
                    begin
                        esc_next = fut_pkg::ESC_FIRST;
                    end
                    else
                    begin
                        dec_en = 1'b1;
                    end
                end
                fut_pkg::ESC_FIRST:
                begin
                    hns_next = {hex[3:0], 4'd0};
                    esc_next = fut_pkg::ESC_SECOND;
                end
                fut_pkg::ESC_SECOND:
                begin
                    dec_ch   = hns_reg + hex;
                    dec_en   = 1'b1;
                    esc_next = fut_pkg::ESC_NONE;
                    hns_next = 8'd0;
                end
                default:
                begin
                    esc_next = fut_pkg::ESC_NONE;
                end
            endcase
        end

        if (dec_en)
        begin
            if (dec_ch == 8'd0)
            begin
                muted_next = 1'b1;
            end
            else if (!value_reg && dec_ch == fut_pkg::CH_EQ)
            begin
                value_next = 1'b1;
                has_char   = 1'b1;
                char_tok   = '{data: 8'd0, kind: fut_pkg::KIND_NAME_END};
            end
            else
            begin
                has_char = 1'b1;
                char_tok = '{data: dec_ch,
                             kind: value_reg ? fut_pkg::KIND_VALUE : fut_pkg::KIND_NAME};
            end
        end

        entry = '{count: 2'd0, tok0: end_tok, tok1: end_tok};
        if (in_byte == fut_pkg::CH_AMP)
        begin
            // An ampersand only closes the pair, even on the final byte.
            entry.count = 2'd1;
        end
        else if (has_char && last_byte)
        begin
            entry.count = 2'd2;
            entry.tok0  = char_tok;
        end
        else if (has_char)
        begin
            entry.count = 2'd1;
            entry.tok0  = char_tok;
        end
        else if (last_byte)
        begin
            entry.count = 2'd1;
        end

        if (in_byte == fut_pkg::CH_AMP || last_byte)
        begin
            value_next = 1'b0;
            esc_next   = fut_pkg::ESC_NONE;
            hns_next   = 8'd0;
            muted_next = 1'b0;
        end

        push.push  = accept && (entry.count != 2'd0);
        push.entry = entry;
    end

endmodule

// File: hw/rtl/fut_queue.sv
module fut_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  fut_pkg::push_t   push,
    input  logic             pop,
    output fut_pkg::qstat_t  stat
);

    fut_pkg::entry_t                  mem_reg [fut_pkg::QUEUE_DEPTH];
    logic [fut_pkg::QPTR_W-1:0]       wr_reg, wr_next;
    logic [fut_pkg::QPTR_W-1:0]       rd_reg, rd_next;
    logic [fut_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            mem_reg[wr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        wr_next  = push.push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push.push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push.push && pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        stat.valid = (cnt_reg != '0);
        stat.full  = (cnt_reg == fut_pkg::QCNT_W'(fut_pkg::QUEUE_DEPTH));
        stat.entry = mem_reg[rd_reg];
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= fut_pkg::QCNT_W'(fut_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> !stat.full)
        else $error("push into full queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || stat.full) |-> wr_reg == rd_reg)
        else $error("queue pointers disagree with count");

endmodule

// File: hw/rtl/fut_back.sv
module fut_back (
    input  logic             clk,
    input  logic             rst_n,
    input  fut_pkg::qstat_t  stat,
    output logic             pop,
    output logic             token_valid,
    input  logic             token_stall,
    output logic [7:0]       out_byte,
    output logic [1:0]       kind
);

    logic [1:0]        cnt_reg, cnt_next;
    fut_pkg::token_t   tok0_reg, tok0_next;
    fut_pkg::token_t   tok1_reg, tok1_next;
    logic              fire;
    logic              drained;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok0_reg <= tok0_next;
        tok1_reg <= tok1_next;
    end

    always_comb
    begin
        token_valid = (cnt_reg != 2'd0);
        fire        = token_valid && !token_stall;
        // The holding register is free once its last token leaves.
        drained     = (cnt_reg == 2'd0) || (fire && cnt_reg == 2'd1);
        pop         = stat.valid && drained;
        cnt_next    = cnt_reg;
        tok0_next   = tok0_reg;
        tok1_next   = tok1_reg;
        if (pop)
        begin
            cnt_next  = stat.entry.count;
            tok0_next = stat.entry.tok0;
            tok1_next = stat.entry.tok1;
        end
        else if (fire && cnt_reg == 2'd2)
        begin
            cnt_next  = 2'd1;
            tok0_next = tok1_reg;
        end
        else if (fire)
        begin
            cnt_next = 2'd0;
        end
        out_byte = tok0_reg.data;
        kind     = tok0_reg.kind;
    end

    a_entry_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> stat.entry.count == 2'd1 || stat.entry.count == 2'd2)
        else $error("empty entry taken from queue");

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cnt_reg == 2'd2) |=> token_valid && tok0_reg == $past(tok1_reg))
        else $error("second token lost");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("holding count out of range");

endmodule

// File: hw/rtl/form_urlencoded_tokenizer.sv
// Form-urlencoded query tokenizer.
// Input channel: one encoded byte per request on in_byte, with last_byte set on
// the final byte of the string; a request is taken when byte_valid is high and
// byte_stall is low. Output channel: one token per request on out_byte and kind
// (0 name char, 1 value char, 2 name ended, 3 pair ended), taken when
// token_valid is high and token_stall is low; out_byte is zero for end marks.
// Each byte gives zero, one or two tokens. A byte is classified and decoded in
// the cycle it is taken and its tokens are written to a four-entry queue; the
// output stage loads an entry into its holding register once that register is
// free, and offers the byte's tokens from there. One byte is taken per cycle
// while the queue has room; the output moves one token per cycle while
// token_stall is low, so a byte that gives two tokens (a character on the last
// byte) holds the output stage for both of its tokens.
// byte_stall is high only when the queue is full, which happens when the token
// receiver stalls or two-token bytes pile up; it never depends on token_stall
// in the same cycle. A stalled token stays on the output unchanged.
// Reset clears the pair state (name part, no escape pending, not muted), empties
// the queue and drops token_valid.
module form_urlencoded_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  in_byte,
    input  logic        last_byte,
    output logic        token_valid,
    input  logic        token_stall,
    output logic [7:0]  out_byte,
    output logic [1:0]  kind
);

    fut_pkg::push_t   push;
    fut_pkg::qstat_t  stat;
    logic             pop;
    logic             accept;

    assign byte_stall = stat.full;
    assign accept     = byte_valid && !stat.full;

    fut_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .last_byte (last_byte),
        .push      (push)
    );

    fut_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .stat  (stat)
    );

    fut_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .stat        (stat),
        .pop         (pop),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .out_byte    (out_byte),
        .kind        (kind)
    );

endmodule
